[rtl/mma_pkg.sv]
// shared types and constants for the multichannel moving average
package mma_pkg;

    // default sizing
    localparam int WINDOW_DEF   = 8;
    localparam int CHANNELS_DEF = 11;

    // fixed field widths
    localparam int CH_W  = 4;
    localparam int SMP_W = 10;

    // input beat
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [CH_W-1:0]  channel_out;
        logic [SMP_W-1:0] average;
    } t_out_beat;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic rd;        // read the replaced ring entry
        logic upd;       // update channel state, start the divide
        logic step;      // one restoring divide step
        logic out_load;  // move the result into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_range;  // captured channel is below the channel count
        logic out_busy;  // output register holds a beat that is not taken
    } t_status;

endpackage

[rtl/mma_ctrl.sv]
// controller state machine for the multichannel moving average
module mma_ctrl #(
    parameter int SUM_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mma_pkg::t_status i_status,
    output mma_pkg::t_cmd    o_cmd
);
    import mma_pkg::*;

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_status.in_range ? S_UPD : S_DONE;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/mma_dp.sv]
// datapath: sample ring memory, per-channel state, serial divider, output register
module mma_dp #(
    parameter int WINDOW   = mma_pkg::WINDOW_DEF,
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int SUM_W    = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mma_pkg::t_in_beat  i_in_data,
    input  mma_pkg::t_cmd      i_cmd,
    output mma_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mma_pkg::t_out_beat o_out_data
);
    import mma_pkg::*;

    localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // captured beat
    logic [CH_W-1:0]  r_ch;
    logic [SMP_W-1:0] r_smp;

    // per-channel state
    logic [SUM_W-1:0]  r_sum_arr  [CHANNELS];
    logic [POS_W-1:0]  r_pos_arr  [CHANNELS];
    logic [FILL_W-1:0] r_fill_arr [CHANNELS];

    // sample ring, never cleared: an entry's data is only used once the window is full
    logic [SMP_W-1:0] r_ring [DEPTH];
    logic [SMP_W-1:0] r_rd_data;

    // divider
    logic [SUM_W-1:0]  r_quo;
    logic [FILL_W-1:0] r_rem;
    logic [FILL_W-1:0] r_den;

    // output register
    logic      r_out_valid;
    t_out_beat r_out;

    logic [IDX_W-1:0]  ch_idx;
    logic              in_range;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  nxt_pos;
    logic [FILL_W-1:0] cur_fill;
    logic [FILL_W-1:0] nxt_fill;
    logic              full;
    logic [SMP_W-1:0]  old_smp;
    logic [SUM_W-1:0]  new_sum;
    logic [ADDR_W-1:0] addr;
    logic [FILL_W:0]   trial;
    logic              q_bit;

    // channel decode and ring address
    assign in_range = ({1'b0, r_ch} < (CH_W + 1)'(CHANNELS));
    assign ch_idx   = r_ch[IDX_W-1:0];
    assign cur_pos  = r_pos_arr[ch_idx];
    assign cur_fill = r_fill_arr[ch_idx];
    assign addr     = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(cur_pos);

    // running sum update
    assign full     = (cur_fill == FILL_W'(WINDOW));
    assign old_smp  = full ? r_rd_data : '0;
    assign new_sum  = r_sum_arr[ch_idx] - SUM_W'(old_smp) + SUM_W'(r_smp);
    assign nxt_pos  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
    assign nxt_fill = full ? cur_fill : cur_fill + 1'b1;

    // restoring divide step
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign q_bit = (trial >= {1'b0, r_den});

    assign o_status.in_range = in_range;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // beat capture and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_in_data.channel;
            r_smp <= i_in_data.sample;
        end
        if (i_cmd.upd) begin
            r_quo <= new_sum;
            r_rem <= '0;
            r_den <= nxt_fill;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? FILL_W'(trial - {1'b0, r_den}) : FILL_W'(trial);
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_ring[addr] <= r_smp;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_ring[addr];
        end
    end

    // per-channel sum, position and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum_arr[i]  <= '0;
                r_pos_arr[i]  <= '0;
                r_fill_arr[i] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_sum_arr[ch_idx]  <= new_sum;
            r_pos_arr[ch_idx]  <= nxt_pos;
            r_fill_arr[ch_idx] <= nxt_fill;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.channel_out <= r_ch;
            r_out.average     <= in_range ? r_quo[SMP_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/multichannel_moving_average.sv]
// top level of the multichannel moving average
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
// sample: a channel number and a 10-bit unsigned sample. Each channel keeps
// the last WINDOW samples, their running sum, a write position and a fill
// count. Output channel (o_out_valid / i_out_ready / o_out_data) returns one
// beat per sample: the channel and the sum divided by the fill count,
// truncated, so the mean is correct while the window is still filling.
// A channel at or above CHANNELS changes nothing and returns average zero.
// The controller steps through idle, read, update, divide and done; the
// restoring divider yields one quotient bit per cycle over SUM_W quotient
// bits (13 with the default sizing), and a new sample is taken only once
// the last result has moved to the output register. Out-of-range channels
// skip the update and the divide, going from read straight to done.
// The result sits in an output register, so when the receiver stalls the
// next sample is still accepted and worked on; it then waits until the
// register frees. Synchronous reset clears all channel state and the output
// valid at once; the ring is never swept, since an entry is used only after
// its channel's window is full.
module multichannel_moving_average #(
    parameter int WINDOW   = mma_pkg::WINDOW_DEF,
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mma_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mma_pkg::t_out_beat o_out_data
);
    import mma_pkg::*;

    localparam int SUM_W = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);

    t_cmd    cmd;
    t_status status;

    // controller
    mma_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    mma_dp #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS),
        .SUM_W    (SUM_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/mma_checker.sv]
// port-level checks for the multichannel moving average, bound to the top level
module mma_checker #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mma_pkg::t_out_beat o_out_data
);
    import mma_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one sample at a time: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready held after accepted beat");

    // unknown channels average to zero
    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({1'b0, o_out_data.channel_out} >= (CH_W + 1)'(CHANNELS))
        |-> o_out_data.average == '0)
        else $error("nonzero average for unknown channel");

    // the output valid is low when reset has just been released
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output beat without input beat");

endmodule

bind multichannel_moving_average mma_checker #(
    .CHANNELS (CHANNELS)
) u_mma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
